### rtl/dsp_pkg.sv
// Package for the date string parser: parse positions, character codes,
// field widths and the result record shared by all modules. No dependencies.
`default_nettype none

package dsp_pkg;

    localparam int unsigned FIELD_W = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned CH_W    = 8;

    localparam logic [CH_W-1:0] C_TERM_CH = 8'h00;
    localparam logic [CH_W-1:0] C_ZERO_CH = 8'h30;
    localparam logic [CH_W-1:0] C_NINE_CH = 8'h39;
    localparam logic [CH_W-1:0] C_DOT_CH  = 8'h2E;

    localparam logic [FIELD_W-1:0] C_PIVOT_YY   = 7'd70;
    localparam logic [FIELD_W-1:0] C_TEN        = 7'd10;
    localparam logic [YEAR_W-1:0]  C_HUNDRED    = 14'd100;
    localparam logic [YEAR_W-1:0]  C_CENT_20    = 14'd2000;
    localparam logic [YEAR_W-1:0]  C_CENT_19    = 14'd1900;
    localparam logic [YEAR_W-1:0]  C_YEAR_RESET = 14'd1970;

    typedef enum logic [3:0] {
        P_MON_T    = 4'd0,
        P_MON_U    = 4'd1,
        P_DAY_T    = 4'd2,
        P_DAY_U    = 4'd3,
        P_HR_T     = 4'd4,
        P_HR_U     = 4'd5,
        P_MIN_T    = 4'd6,
        P_MIN_U    = 4'd7,
        P_AFT_MIN  = 4'd8,
        P_YR1_U    = 4'd9,
        P_AFT_YY   = 4'd10,
        P_YR2_U    = 4'd11,
        P_AFT_CCYY = 4'd12,
        P_SEC_T    = 4'd13,
        P_SEC_U    = 4'd14,
        P_DONE     = 4'd15
    } t_pos;

    typedef struct packed {
        logic               valid_res;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [YEAR_W-1:0]  year;
    } t_result;

endpackage

`default_nettype wire

### rtl/dsp_parser.sv
// Character parser: parse position, digit pairs and sticky error, updated
// once per accepted beat. Emits the result record at the terminator. Uses dsp_pkg.
`default_nettype none

module dsp_parser
    import dsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_beat,
    input  wire logic [CH_W-1:0]   i_ch,
    input  wire logic [YEAR_W-1:0] i_default_year,
    output logic                   o_push,
    output t_result                o_res
);

    t_pos               r_pos,    n_pos;
    logic               r_err,    n_err;
    logic [3:0]         r_tens,   n_tens;
    logic [FIELD_W-1:0] r_month,  n_month;
    logic [FIELD_W-1:0] r_day,    n_day;
    logic [FIELD_W-1:0] r_hour,   n_hour;
    logic [FIELD_W-1:0] r_minute, n_minute;
    logic [FIELD_W-1:0] r_second, n_second;
    logic [FIELD_W-1:0] r_fyp,    n_fyp;
    logic [YEAR_W-1:0]  r_year,   n_year;

    logic               dig, dot, term;
    logic [3:0]         d;
    logic [FIELD_W-1:0] pair;
    logic [YEAR_W-1:0]  year4, cent_year;

    assign term = (i_ch == C_TERM_CH);
    assign dig  = (i_ch >= C_ZERO_CH) && (i_ch <= C_NINE_CH);
    assign dot  = (i_ch == C_DOT_CH);
    assign d    = dig ? i_ch[3:0] : 4'd0;
    assign pair = FIELD_W'({3'd0, r_tens} * C_TEN + {3'd0, d});
    assign year4 = YEAR_W'({7'd0, r_fyp} * C_HUNDRED + {7'd0, pair});
    assign cent_year = (r_fyp < C_PIVOT_YY) ? (C_CENT_20 + {7'd0, r_fyp})
                                            : (C_CENT_19 + {7'd0, r_fyp});

    // next state
    always_comb begin
        n_pos = r_pos;
        n_err = r_err;
        if (!r_err) begin
            unique case (r_pos)
                P_MON_T, P_MON_U, P_DAY_T, P_DAY_U, P_HR_T, P_HR_U,
                P_MIN_T, P_MIN_U, P_YR1_U, P_YR2_U, P_SEC_T: begin
                    if (dig) n_pos = t_pos'(r_pos + 4'd1);
                    else     n_err = 1'b1;
                end
                P_SEC_U: begin
                    if (dig) n_pos = P_DONE;
                    else     n_err = 1'b1;
                end
                P_AFT_MIN, P_AFT_YY: begin
                    if (dot)      n_pos = P_SEC_T;
                    else if (dig) n_pos = t_pos'(r_pos + 4'd1);
                    else          n_err = 1'b1;
                end
                P_AFT_CCYY: begin
                    if (dot) n_pos = P_SEC_T;
                    else     n_err = 1'b1;
                end
                P_DONE: n_err = 1'b1;
            endcase
        end
    end

    // datapath
    always_comb begin
        n_tens   = r_tens;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_fyp    = r_fyp;
        n_year   = r_year;
        if (!r_err) begin
            unique case (r_pos)
                P_MON_T, P_DAY_T, P_HR_T, P_MIN_T, P_SEC_T: n_tens = d;
                P_MON_U: n_month  = pair;
                P_DAY_U: n_day    = pair;
                P_HR_U:  n_hour   = pair;
                P_MIN_U: n_minute = pair;
                P_YR1_U: n_fyp    = pair;
                P_YR2_U: n_year   = year4;
                P_SEC_U: n_second = pair;
                P_AFT_MIN: begin
                    if (dot)      n_year = i_default_year;
                    else if (dig) n_tens = d;
                end
                P_AFT_YY: begin
                    if (dot)      n_year = cent_year;
                    else if (dig) n_tens = d;
                end
                P_AFT_CCYY, P_DONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && term)) begin
            r_pos    <= P_MON_T;
            r_err    <= 1'b0;
            r_tens   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_fyp    <= '0;
            r_year   <= '0;
        end else if (i_beat) begin
            r_pos    <= n_pos;
            r_err    <= n_err;
            r_tens   <= n_tens;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_fyp    <= n_fyp;
            r_year   <= n_year;
        end
    end

    logic              ok;
    logic [YEAR_W-1:0] yr;

    always_comb begin
        ok = !r_err && ((r_pos == P_AFT_MIN) || (r_pos == P_AFT_YY) ||
                        (r_pos == P_AFT_CCYY) || (r_pos == P_DONE));
        priority if (r_pos == P_AFT_MIN) yr = i_default_year;
        else if (r_pos == P_AFT_YY)      yr = cent_year;
        else                             yr = r_year;
        o_res = '0;
        if (ok) begin
            o_res.valid_res = 1'b1;
            o_res.month     = r_month;
            o_res.day       = r_day;
            o_res.hour      = r_hour;
            o_res.minute    = r_minute;
            o_res.second    = r_second;
            o_res.year      = yr;
        end
    end

    assign o_push = i_beat && term;

endmodule

`default_nettype wire

### rtl/dsp_out_buf.sv
// Result register with a skid stage, so the input side stall is registered.
// Uses dsp_pkg for the result record.
`default_nettype none

module dsp_out_buf
    import dsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    logic    r_ov, r_sv;
    t_result r_out, r_skid;
    logic    take;

    assign take = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || take) r_ov <= 1'b1;
            else               r_sv <= 1'b1;
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) r_out <= r_skid;
        end else if (i_push) begin
            if (!r_ov || take) r_out  <= i_res;
            else               r_skid <= i_res;
        end
    end

    assign o_full  = r_sv;
    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

`default_nettype wire

### rtl/date_string_parser_unit.sv
// Top level of the date string parser: config register, parser, result buffer.
// Depends on dsp_pkg, dsp_parser and dsp_out_buf.
//
// Parses mmddhhmm[ccyy|yy][.ss], one character per input beat; a zero
// character ends the string and yields one result beat carrying valid_res
// and all fields (all zero when valid_res is low), after which the parser
// re-arms. A new character is taken every cycle while the input is not
// stalled; the terminator's result is registered in a result register
// backed by a one-entry skid, so input stalls only when both hold an
// untaken result. default_year resets to 1970 and is sampled at the dot
// or the terminator; the config port is always ready.
`default_nettype none

module date_string_parser_unit
    import dsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [YEAR_W-1:0]  i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CH_W-1:0]    i_ch,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_valid_res,
    output logic [FIELD_W-1:0]      o_month,
    output logic [FIELD_W-1:0]      o_day,
    output logic [FIELD_W-1:0]      o_hour,
    output logic [FIELD_W-1:0]      o_minute,
    output logic [FIELD_W-1:0]      o_second,
    output logic [YEAR_W-1:0]       o_year
);

    logic [YEAR_W-1:0] r_default_year;
    logic              beat, push, full;
    t_result           res, out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_year <= C_YEAR_RESET;
        end else if (i_cfg_valid) begin
            r_default_year <= i_cfg_data;
        end
    end

    assign o_in_stall = full;
    assign beat       = i_in_valid && !full;

    dsp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (beat),
        .i_ch           (i_ch),
        .i_default_year (r_default_year),
        .o_push         (push),
        .o_res          (res)
    );

    dsp_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_valid_res = out_res.valid_res;
    assign o_month     = out_res.month;
    assign o_day       = out_res.day;
    assign o_hour      = out_res.hour;
    assign o_minute    = out_res.minute;
    assign o_second    = out_res.second;
    assign o_year      = out_res.year;

endmodule

`default_nettype wire

### rtl/dsp_checker.sv
// Port-level checker for date_string_parser_unit, bound to the top level.
// Depends on dsp_pkg.
`default_nettype none

module dsp_port_checker
    import dsp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_valid_res,
    input wire logic [FIELD_W-1:0] o_month,
    input wire logic [FIELD_W-1:0] o_day,
    input wire logic [FIELD_W-1:0] o_hour,
    input wire logic [FIELD_W-1:0] o_minute,
    input wire logic [FIELD_W-1:0] o_second,
    input wire logic [YEAR_W-1:0]  o_year
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result beat or stall right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_valid_res)
            && $stable(o_month) && $stable(o_second) && $stable(o_year))
        else $error("stalled result beat changed");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_month == 0 && o_day == 0 &&
            o_hour == 0 && o_minute == 0 && o_second == 0 && o_year == 0)
        else $error("invalid result carries non-zero fields");

    a_two_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |-> o_month <= 7'd99 && o_day <= 7'd99 &&
            o_hour <= 7'd99 && o_minute <= 7'd99 && o_second <= 7'd99)
        else $error("field beyond two decimal digits");

endmodule

bind date_string_parser_unit dsp_port_checker u_dsp_checker (.*);

`default_nettype wire

### verif/dsp_checker.sv
// Checker for the date string parser: watches the config, character and result
// channels, predicts each result beat and compares it field by field.
// Depends on dsp_pkg.

module dsp_checker
    import dsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [YEAR_W-1:0]  i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [CH_W-1:0]    i_ch,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_valid_res,
    input  wire logic [FIELD_W-1:0] i_month,
    input  wire logic [FIELD_W-1:0] i_day,
    input  wire logic [FIELD_W-1:0] i_hour,
    input  wire logic [FIELD_W-1:0] i_minute,
    input  wire logic [FIELD_W-1:0] i_second,
    input  wire logic [YEAR_W-1:0]  i_year,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_dates_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_pos               pos;
    logic [3:0]         tens;
    logic [FIELD_W-1:0] mon_v;
    logic [FIELD_W-1:0] day_v;
    logic [FIELD_W-1:0] hour_v;
    logic [FIELD_W-1:0] min_v;
    logic [FIELD_W-1:0] sec_v;
    logic [FIELD_W-1:0] yy_first;
    logic [YEAR_W-1:0]  year_v;
    logic               fmt_err;
    logic [YEAR_W-1:0]  default_year;

    t_result expected_dates [$];
    int      fail_count    = 0;
    int      dates_checked = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = expected_dates.size();
    assign o_dates_checked = dates_checked;

    function automatic logic [YEAR_W-1:0] century(input logic [FIELD_W-1:0] yy);
        century = (yy < C_PIVOT_YY) ? C_CENT_20 + yy : C_CENT_19 + yy;
    endfunction

    task automatic clear_parse();
        pos      = P_MON_T;
        tens     = '0;
        mon_v    = '0;
        day_v    = '0;
        hour_v   = '0;
        min_v    = '0;
        sec_v    = '0;
        yy_first = '0;
        year_v   = '0;
        fmt_err  = 1'b0;
    endtask

    task automatic parse_char(input logic [CH_W-1:0] c);
        logic               is_digit;
        logic [3:0]         digit;
        logic [FIELD_W-1:0] pair;
        is_digit = (c >= C_ZERO_CH) && (c <= C_NINE_CH);
        digit    = is_digit ? 4'(c - C_ZERO_CH) : 4'd0;
        pair     = tens * C_TEN + digit;
        if (fmt_err) return;
        case (pos)
            P_MON_T, P_DAY_T, P_HR_T, P_MIN_T, P_SEC_T: begin
                if (!is_digit) begin
                    fmt_err = 1'b1;
                end else begin
                    tens = digit;
                    pos  = t_pos'(pos + 4'd1);
                end
            end
            P_MON_U, P_DAY_U, P_HR_U, P_MIN_U, P_YR1_U, P_YR2_U, P_SEC_U: begin
                if (!is_digit) begin
                    fmt_err = 1'b1;
                end else begin
                    case (pos)
                        P_MON_U: mon_v    = pair;
                        P_DAY_U: day_v    = pair;
                        P_HR_U:  hour_v   = pair;
                        P_MIN_U: min_v    = pair;
                        P_YR1_U: yy_first = pair;
                        P_YR2_U: year_v   = yy_first * C_HUNDRED + pair;
                        default: sec_v    = pair;
                    endcase
                    pos = t_pos'(pos + 4'd1);
                end
            end
            P_AFT_MIN, P_AFT_YY: begin
                if (c == C_DOT_CH) begin
                    year_v = (pos == P_AFT_MIN) ? default_year : century(yy_first);
                    pos    = P_SEC_T;
                end else if (is_digit) begin
                    tens = digit;
                    pos  = t_pos'(pos + 4'd1);
                end else begin
                    fmt_err = 1'b1;
                end
            end
            P_AFT_CCYY: begin
                if (c == C_DOT_CH) begin
                    pos = P_SEC_T;
                end else begin
                    fmt_err = 1'b1;
                end
            end
            default: fmt_err = 1'b1;
        endcase
    endtask

    task automatic close_string(output t_result r);
        r = '0;
        if (!fmt_err && (pos == P_AFT_MIN || pos == P_AFT_YY ||
                         pos == P_AFT_CCYY || pos == P_DONE)) begin
            r.valid_res = 1'b1;
            r.month     = mon_v;
            r.day       = day_v;
            r.hour      = hour_v;
            r.minute    = min_v;
            r.second    = sec_v;
            r.year      = (pos == P_AFT_MIN) ? default_year :
                          (pos == P_AFT_YY)  ? century(yy_first) : year_v;
        end
        clear_parse();
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            default_year = C_YEAR_RESET;
            expected_dates.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    $error("result beat with no date string pending");
                    fail_count++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("valid_res", want.valid_res, i_valid_res);
                    check_field("month", want.month, i_month);
                    check_field("day", want.day, i_day);
                    check_field("hour", want.hour, i_hour);
                    check_field("minute", want.minute, i_minute);
                    check_field("second", want.second, i_second);
                    check_field("year", want.year, i_year);
                    dates_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_ch == C_TERM_CH) begin
                    close_string(want);
                    expected_dates.push_back(want);
                end else begin
                    parse_char(i_ch);
                end
            end
            // the register takes the new year after this edge's beat has used the old one
            if (i_cfg_valid && i_cfg_ready) begin
                default_year = i_cfg_data;
            end
        end
    end

endmodule

### verif/tb_date_string_parser_unit.sv
// Testbench top for date_string_parser_unit: drives date strings and default
// year writes with random gaps and stalls. Depends on dsp_pkg and dsp_checker.

module tb_date_string_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dsp_pkg::*;

    localparam int RANDOM_CHARS = 1300;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [YEAR_W-1:0]  cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic [CH_W-1:0]    ch        = '0;
    logic               out_stall = 1'b0;

    logic               cfg_ready;
    logic               in_stall;
    logic               out_valid;
    logic               valid_res;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [YEAR_W-1:0]  year;

    int fail_count;
    int pending;
    int dates_checked;
    int chars_sent = 0;
    bit no_idle    = 1'b0;

    string directed_dates [8] = '{
        "", "12312359", "0229235969", "9999999970.59", "000000009999",
        "0101000x", "01010000.5", "010100001999.301"
    };

    date_string_parser_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_ch        (ch),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_valid_res (valid_res),
        .o_month     (month),
        .o_day       (day),
        .o_hour      (hour),
        .o_minute    (minute),
        .o_second    (second),
        .o_year      (year)
    );

    dsp_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_ch            (ch),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_valid_res     (valid_res),
        .i_month         (month),
        .i_day           (day),
        .i_hour          (hour),
        .i_minute        (minute),
        .i_second        (second),
        .i_year          (year),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_dates_checked (dates_checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] rand_digit();
        return C_ZERO_CH + CH_W'($urandom_range(0, 9));
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_char(input logic [CH_W-1:0] c);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_year(input logic [YEAR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_string();
        logic [CH_W-1:0] text [$];
        int              kind;
        int              keep;
        no_idle = ($urandom_range(0, 7) == 0);
        kind    = $urandom_range(0, 99);
        repeat (8) text.push_back(rand_digit());
        case ($urandom_range(0, 2))
            1: repeat (2) text.push_back(rand_digit());
            2: repeat (4) text.push_back(rand_digit());
            default: ;
        endcase
        if ($urandom_range(0, 1)) begin
            text.push_back(C_DOT_CH);
            repeat (2) text.push_back(rand_digit());
        end
        if (kind >= 96) begin
            text.delete();
            repeat ($urandom_range(0, 12)) text.push_back(CH_W'($urandom_range(1, 255)));
        end else if (kind >= 92) begin
            repeat ($urandom_range(1, 3)) begin
                text.push_back($urandom_range(0, 1) ? rand_digit() :
                               CH_W'($urandom_range(1, 255)));
            end
        end else if (kind >= 85) begin
            keep = $urandom_range(0, text.size() - 1);
            while (text.size() > keep) void'(text.pop_back());
        end else if (kind >= 75) begin
            text[$urandom_range(0, text.size() - 1)] = CH_W'($urandom_range(1, 255));
        end
        foreach (text[i]) send_char(text[i]);
        send_char(C_TERM_CH);
    endtask

    initial begin
        int gap;
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(30, 80) :
                    $urandom_range(1, 4)) @(negedge clk);
        end
    end

    initial begin
        int chars_at_start;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_dates[i]) begin
            for (int k = 0; k < directed_dates[i].len(); k++) send_char(directed_dates[i][k]);
            send_char(C_TERM_CH);
        end
        chars_at_start = chars_sent;
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: write_year(YEAR_W'(0));
                1: write_year(YEAR_W'(9999));
                2: write_year(YEAR_W'($urandom_range(0, 9999)));
                default: write_year(C_YEAR_RESET);
            endcase
            while (chars_sent < chars_at_start + (phase + 1) * RANDOM_CHARS / 4) begin
                send_random_string();
                if ($urandom_range(0, 19) == 0) drain();
            end
        end
        drain();
        repeat (10) @(negedge clk);
        $display("Sent %0d characters and checked %0d date strings", chars_sent, dates_checked);
        $display("Default year covered 1970, 0, 9999 and a random value");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
